// ===== hw/rtl/psieve_pkg.sv =====
// ---------------------------------------------------------------------------
// psieve_pkg: shared types and codes for the prime sieve table
// Command and status codes, the sequencer's control word and the flags that
// the datapath returns to the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package psieve_pkg;

  // Command codes carried by an input beat.
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes carried by a result beat.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABOVE    = 2'd1;
  localparam logic [1:0] ST_NO_TABLE = 2'd2;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_DISP  = 4'd1,
    S_B0    = 4'd2,
    S_B1    = 4'd3,
    S_FILL  = 4'd4,
    S_SV0   = 4'd5,
    S_SV1   = 4'd6,
    S_SV2   = 4'd7,
    S_SV3   = 4'd8,
    S_SV4   = 4'd9,
    S_DONE  = 4'd10,
    S_Q0    = 4'd11,
    S_Q1    = 4'd12
  } step_t;

  // Memory address source.
  typedef enum logic [2:0] {
    A_ZERO,
    A_ONE,
    A_K,
    A_N,
    A_NUM
  } asel_t;

  // Operation on the multiple counter k.
  typedef enum logic [2:0] {
    K_HOLD,
    K_TWO,
    K_INC,
    K_DBL,
    K_ADDN
  } kop_t;

  // Operation on the candidate n and its square.
  typedef enum logic [1:0] {
    N_HOLD,
    N_TWO,
    N_INC
  } nop_t;

  // Result beat produced by a step.
  typedef enum logic [1:0] {
    E_NONE,
    E_BUILD,
    E_QUERY
  } emit_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_QUERY,
    C_K_GT_LIM,
    C_K_LT_LIM,
    C_SQ_GT_LIM,
    C_NOT_PRIME,
    C_STEP_LE_LIM
  } cond_t;

  // One control word of the program.
  typedef struct packed {
    logic  in_rdy;
    logic  we;
    logic  wdata;
    asel_t asel;
    kop_t  kop;
    nop_t  nop;
    emit_t emit;
    logic  hold;
    cond_t cond;
    step_t target;
  } ctl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic accept;
    logic is_query;
    logic k_gt_lim;
    logic k_lt_lim;
    logic sq_gt_lim;
    logic not_prime;
    logic step_le_lim;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psieve_in_if.sv =====
// ---------------------------------------------------------------------------
// psieve_in_if: request channel of the prime sieve table
// Carries a command and a number with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface psieve_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] number;

  modport source (output valid, output cmd, output number, input ready);
  modport sink   (input valid, input cmd, input number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/psieve_out_if.sv =====
// ---------------------------------------------------------------------------
// psieve_out_if: result channel of the prime sieve table
// Carries the primality bit and a status code with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface psieve_out_if;
  logic       valid;
  logic       ready;
  logic       is_prime;
  logic [1:0] status;

  modport source (output valid, output is_prime, output status, input ready);
  modport sink   (input valid, input is_prime, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prime_sieve_table_top.sv =====
// ---------------------------------------------------------------------------
// prime_sieve_table_top: one-bit primality table built by a sieve
// Requests arrive on req (cmd, number); each request yields one result beat
// on rsp (is_prime, status). cfg_we/cfg_data write the limit register, which
// the next build uses; write it only while the block is idle.
// A build beat marks 0 and 1 composite, fills 2..limit as prime, then for
// every n with n*n <= limit still marked prime clears 2n, 3n, ... up to the
// limit. Its result is is_prime 0, status ok. A query beat returns the bit
// for number, or status 1 above the built limit, or status 2 before any
// build. Intake is open only in the idle step of the microcode sequencer.
// A query passes the dispatch step and the two query steps; its result is
// registered as it leaves the last one, and the next request is taken
// when the sequencer is back in its idle step. A build's length is set by
// the single table port, one write per cycle. The result sits in an output
// register; while rsp is stalled the block still accepts the next beat and
// runs it up to its result step, where it waits for the register to drain.
// Reset clears the sequencer, the result valid, the build record and sets
// the limit to 65535; the table itself is not cleared, since no query can
// read an entry that was never written.
// ---------------------------------------------------------------------------
`default_nettype none

module prime_sieve_table_top
  import psieve_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [15:0]  cfg_data,
  psieve_in_if.sink    req,
  psieve_out_if.source rsp
);

  ctl_t   ctl;
  flags_t flags;

  // Sequencer: program table and step counter.
  psieve_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // Datapath: counters, table memory and result register.
  psieve_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp),
    .ctl      (ctl),
    .flags    (flags)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/psieve_seq.sv =====
// ---------------------------------------------------------------------------
// psieve_seq: microcoded sequencer of the prime sieve table
// Holds the step counter, the program table and the jump logic.
// ---------------------------------------------------------------------------
`default_nettype none

module psieve_seq
  import psieve_pkg::*;
(
  input  wire    clk,
  input  wire    rst,
  input  flags_t flags,
  output ctl_t   ctl
);

  // Program table: one control word per step.
  function automatic ctl_t rom(step_t s);
    ctl_t c;
    c.in_rdy = 1'b0;
    c.we     = 1'b0;
    c.wdata  = 1'b0;
    c.asel   = A_N;
    c.kop    = K_HOLD;
    c.nop    = N_HOLD;
    c.emit   = E_NONE;
    c.hold   = 1'b0;
    c.cond   = C_NEVER;
    c.target = S_IDLE;
    unique case (s)
      S_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = C_NO_ACCEPT;
        c.target = S_IDLE;
      end
      S_DISP: begin
        c.cond   = C_QUERY;
        c.target = S_Q0;
      end
      S_B0: begin
        c.we   = 1'b1;
        c.asel = A_ZERO;
        c.kop  = K_TWO;
      end
      S_B1: begin
        c.we     = 1'b1;
        c.asel   = A_ONE;
        c.cond   = C_K_GT_LIM;
        c.target = S_SV0;
      end
      S_FILL: begin
        c.we     = 1'b1;
        c.wdata  = 1'b1;
        c.asel   = A_K;
        c.kop    = K_INC;
        c.cond   = C_K_LT_LIM;
        c.target = S_FILL;
      end
      S_SV0: begin
        c.nop = N_TWO;
      end
      S_SV1: begin
        c.cond   = C_SQ_GT_LIM;
        c.target = S_DONE;
      end
      S_SV2: begin
        c.kop    = K_DBL;
        c.cond   = C_NOT_PRIME;
        c.target = S_SV4;
      end
      S_SV3: begin
        c.we     = 1'b1;
        c.asel   = A_K;
        c.kop    = K_ADDN;
        c.cond   = C_STEP_LE_LIM;
        c.target = S_SV3;
      end
      S_SV4: begin
        c.nop    = N_INC;
        c.cond   = C_ALWAYS;
        c.target = S_SV1;
      end
      S_DONE: begin
        c.emit   = E_BUILD;
        c.hold   = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
      S_Q0: begin
        c.asel = A_NUM;
      end
      S_Q1: begin
        c.asel   = A_NUM;
        c.emit   = E_QUERY;
        c.hold   = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

  step_t pc;
  step_t pc_next;
  logic  take;

  assign ctl = rom(pc);

  // Jump condition selected by the current control word.
  always_comb begin
    unique case (ctl.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_ACCEPT:   take = !flags.accept;
      C_QUERY:       take = flags.is_query;
      C_K_GT_LIM:    take = flags.k_gt_lim;
      C_K_LT_LIM:    take = flags.k_lt_lim;
      C_SQ_GT_LIM:   take = flags.sq_gt_lim;
      C_NOT_PRIME:   take = flags.not_prime;
      C_STEP_LE_LIM: take = flags.step_le_lim;
      default:       take = 1'b1;
    endcase
  end

  // Next step: hold while a result waits for room, else jump or advance.
  always_comb begin
    if (ctl.hold && !flags.out_free) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctl.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Intake is only open in the idle step.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.in_rdy |-> (pc == S_IDLE))
    else $error("request ready outside the idle step");

  // An accepted beat always leaves the idle step.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    flags.accept |=> (pc == S_DISP))
    else $error("accepted beat did not reach dispatch");

  // A held result step stays put while the output is full.
  a_hold_stays: assert property (@(posedge clk) disable iff (rst)
    (ctl.hold && !flags.out_free) |=> $stable(pc))
    else $error("result step left while output full");

endmodule

`default_nettype wire

// ===== hw/rtl/psieve_dp.sv =====
// ---------------------------------------------------------------------------
// psieve_dp: datapath of the prime sieve table
// Limit register, sieve counters, the one-bit table memory and the result
// register, all driven by the sequencer's control word.
// ---------------------------------------------------------------------------
`default_nettype none

module psieve_dp
  import psieve_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           cfg_we,
  input  wire  [15:0]   cfg_data,
  psieve_in_if.sink     req,
  psieve_out_if.source  rsp,
  input  ctl_t          ctl,
  output flags_t        flags
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [20:0] MAX_IDX = 21'(TABLE_DEPTH - 1);

  logic [15:0]   limit_q;
  logic          cmd_q;
  logic [15:0]   num_q;
  logic [15:0]   lim;
  logic [15:0]   lim_sat;
  logic [16:0]   k;
  logic [8:0]    n;
  logic [16:0]   sq;
  logic          table_built;
  logic [15:0]   built_lim;
  logic          mem [TABLE_DEPTH];
  logic          rd_data;
  logic [AW-1:0] addr;
  logic          out_free;
  logic          accept;
  logic          emit_go;
  logic          q_prime;
  logic [1:0]    q_status;

  // Handshake on both channels.
  assign req.ready = ctl.in_rdy;
  assign accept    = req.valid && ctl.in_rdy;
  assign out_free  = !rsp.valid || rsp.ready;
  assign emit_go   = (ctl.emit != E_NONE) && out_free;

  // The build never covers more than the table holds.
  assign lim_sat = (21'(limit_q) > MAX_IDX) ? 16'(MAX_IDX) : limit_q;

  // Flags for the sequencer's jump conditions.
  always_comb begin
    flags.accept      = accept;
    flags.is_query    = (cmd_q == CMD_QUERY);
    flags.k_gt_lim    = k > {1'b0, lim};
    flags.k_lt_lim    = k < {1'b0, lim};
    flags.sq_gt_lim   = sq > {1'b0, lim};
    flags.not_prime   = !rd_data;
    flags.step_le_lim = ({1'b0, k} + 18'(n)) <= {2'b00, lim};
    flags.out_free    = out_free;
  end

  // Table address source.
  always_comb begin
    unique case (ctl.asel)
      A_ZERO:  addr = '0;
      A_ONE:   addr = AW'(1);
      A_K:     addr = AW'(k);
      A_N:     addr = AW'(n);
      A_NUM:   addr = AW'(num_q);
      default: addr = '0;
    endcase
  end

  // Single-port table memory with registered read.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= ctl.wdata;
    end
    rd_data <= mem[addr];
  end

  // Query answer: a missing table or a number above the built limit takes precedence over the table bit.
  always_comb begin
    if (!table_built) begin
      q_prime  = 1'b0;
      q_status = ST_NO_TABLE;
    end else if (num_q > built_lim) begin
      q_prime  = 1'b0;
      q_status = ST_ABOVE;
    end else begin
      q_prime  = rd_data;
      q_status = ST_OK;
    end
  end

  // Control state: limit register, build record and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q     <= 16'hFFFF;
      table_built <= 1'b0;
      built_lim   <= 16'd0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_q <= cfg_data;
      end
      if (emit_go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (emit_go && (ctl.emit == E_BUILD)) begin
        table_built <= 1'b1;
        built_lim   <= lim;
      end
    end
  end

  // Payload: latched beat, sieve counters and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.cmd;
      num_q <= req.number;
      lim   <= lim_sat;
    end
    unique case (ctl.kop)
      K_HOLD:  k <= k;
      K_TWO:   k <= 17'd2;
      K_INC:   k <= k + 17'd1;
      K_DBL:   k <= {7'd0, n, 1'b0};
      K_ADDN:  k <= k + 17'(n);
      default: k <= k;
    endcase
    unique case (ctl.nop)
      N_HOLD:  begin
        n  <= n;
        sq <= sq;
      end
      N_TWO:   begin
        n  <= 9'd2;
        sq <= 17'd4;
      end
      N_INC:   begin
        n  <= n + 9'd1;
        sq <= sq + {7'd0, n, 1'b1};
      end
      default: begin
        n  <= n;
        sq <= sq;
      end
    endcase
    if (emit_go) begin
      if (ctl.emit == E_QUERY) begin
        rsp.is_prime <= q_prime;
        rsp.status   <= q_status;
      end else begin
        rsp.is_prime <= 1'b0;
        rsp.status   <= ST_OK;
      end
    end
  end

  // Intake never overlaps a table write.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.we |-> !ctl.in_rdy)
    else $error("table written while intake open");

  // Sieve writes stay within the limit of the build.
  a_write_in_limit: assert property (@(posedge clk) disable iff (rst)
    (ctl.we && (ctl.asel == A_K)) |-> (k <= {1'b0, lim}))
    else $error("sieve write beyond limit");

  // A delivered build result records the table.
  a_build_marks: assert property (@(posedge clk) disable iff (rst)
    (emit_go && (ctl.emit == E_BUILD)) |=> (table_built && (built_lim == $past(lim))))
    else $error("build result without table record");

  // The recorded limit never exceeds the table.
  a_built_fits: assert property (@(posedge clk) disable iff (rst)
    table_built |-> (21'(built_lim) <= MAX_IDX))
    else $error("recorded limit beyond table");

endmodule

`default_nettype wire
